/* hw/rtl/cprgd_pkg.sv */
`default_nettype none
package cprgd_pkg;

  localparam int FracBits  = 17;
  localparam int LatBits   = 24;
  localparam int AngleBits = 32;
  localparam int NlBits    = 6;
  localparam int NlLimits  = 58;
  localparam int NlMax     = 59;
  localparam int DivSteps  = 8;
  localparam int DivStages = AngleBits / DivSteps;

  // Zone offset of 60 whole zones plus one half, keeps sums non-negative
  localparam logic [23:0] RoundBias = 24'd7929856;
  localparam logic [22:0] LatWrapAt = 23'd5898240;
  localparam logic signed [23:0] LatFull = 24'sd7864320;

  localparam logic [20:0] NL_LIMIT [NlLimits] = '{
    21'd228731,  21'd323927,  21'd397285,  21'd459395,  21'd514350,  21'd564249,
    21'd610337,  21'd653424,  21'd694073,  21'd732692,  21'd769590,  21'd805007,
    21'd839133,  21'd872122,  21'd904103,  21'd935180,  21'd965445,  21'd994974,
    21'd1023833, 21'd1052080, 21'd1079766, 21'd1106936, 21'd1133630, 21'd1159882,
    21'd1185725, 21'd1211188, 21'd1236298, 21'd1261076, 21'd1285547, 21'd1309729,
    21'd1333640, 21'd1357298, 21'd1380719, 21'd1403916, 21'd1426904, 21'd1449694,
    21'd1472299, 21'd1494729, 21'd1516993, 21'd1539103, 21'd1561065, 21'd1582888,
    21'd1604579, 21'd1626144, 21'd1647588, 21'd1668915, 21'd1690128, 21'd1711227,
    21'd1732211, 21'd1753072, 21'd1773798, 21'd1794367, 21'd1814736, 21'd1834828,
    21'd1854487, 21'd1873356, 21'd1890395, 21'd1900544
  };

  typedef struct packed {
    logic                       valid;
    logic signed [LatBits-1:0]  lat;
    logic [FracBits-1:0]        xe;
    logic [FracBits-1:0]        xo;
  } lat_beat_t;

  typedef struct packed {
    logic                       valid;
    logic signed [LatBits-1:0]  lat;
    logic [NlBits-1:0]          nl;
    logic [FracBits-1:0]        xe;
    logic [FracBits-1:0]        xo;
  } zone_beat_t;

  typedef struct packed {
    logic                       valid;
    logic [NlBits-1:0]          rem;
    logic [AngleBits-1:0]       word;
    logic signed [LatBits-1:0]  lat;
    logic [NlBits-1:0]          nl;
  } div_beat_t;

endpackage
`default_nettype wire

/* hw/rtl/cprgd_lat.sv */
`default_nettype none
module cprgd_lat (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [16:0]         le,
  input  wire logic [16:0]         lo,
  input  wire logic [16:0]         xe,
  input  wire logic [16:0]         xo,
  output cprgd_pkg::lat_beat_t     beat_out
);

  cprgd_pkg::lat_beat_t beat_r, beat_nxt;

  always_comb begin
    logic [22:0] p59;
    logic [22:0] p60;
    logic [23:0] num;
    logic [6:0]  jp;
    logic [5:0]  jm;
    logic [22:0] latu;
    p59  = {6'd0, le} * 23'd59;
    p60  = {6'd0, lo} * 23'd60;
    num  = {1'b0, p59} + cprgd_pkg::RoundBias - {1'b0, p60};
    jp   = num[23:17];
    jm   = (jp >= 7'd60) ? 6'(jp - 7'd60) : jp[5:0];
    latu = {jm, le};
    beat_nxt.valid = in_valid;
    beat_nxt.xe    = xe;
    beat_nxt.xo    = xo;
    if (latu >= cprgd_pkg::LatWrapAt) begin
      beat_nxt.lat = $signed({1'b0, latu}) - cprgd_pkg::LatFull;
    end else begin
      beat_nxt.lat = $signed({1'b0, latu});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule
`default_nettype wire

/* hw/rtl/cprgd_zone.sv */
`default_nettype none
module cprgd_zone (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  cprgd_pkg::lat_beat_t       beat_in,
  output cprgd_pkg::zone_beat_t      beat_out
);

  logic [cprgd_pkg::NlLimits-1:0] ge_r, ge_nxt;
  cprgd_pkg::lat_beat_t           hold_r;
  cprgd_pkg::zone_beat_t          beat_r, beat_nxt;

  // compare magnitude against every zone boundary
  always_comb begin
    logic [22:0] mag;
    mag = beat_in.lat[23] ? 23'(-beat_in.lat) : beat_in.lat[22:0];
    for (int i = 0; i < cprgd_pkg::NlLimits; i++) begin
      ge_nxt[i] = (mag >= {2'b00, cprgd_pkg::NL_LIMIT[i]});
    end
  end

  always_comb begin
    logic [5:0] cnt;
    cnt = '0;
    for (int i = 0; i < cprgd_pkg::NlLimits; i++) begin
      cnt = cnt + 6'(ge_r[i]);
    end
    beat_nxt.valid = hold_r.valid;
    beat_nxt.lat   = hold_r.lat;
    beat_nxt.xe    = hold_r.xe;
    beat_nxt.xo    = hold_r.xo;
    beat_nxt.nl    = 6'(cprgd_pkg::NlMax) - cnt;
  end

  always_ff @(posedge clk) begin
    ge_r <= ge_nxt;
    if (!rst_n) begin
      hold_r.valid <= 1'b0;
      beat_r.valid <= 1'b0;
    end else begin
      hold_r <= beat_in;
      beat_r <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule
`default_nettype wire

/* hw/rtl/cprgd_lon.sv */
`default_nettype none
module cprgd_lon (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  cprgd_pkg::zone_beat_t      beat_in,
  output cprgd_pkg::div_beat_t       beat_out
);

  logic        valid_r;
  logic [6:0]  t_r, t_nxt;
  logic [16:0] xe_r;
  logic [5:0]  nl_r;
  logic signed [23:0] lat_r;
  cprgd_pkg::div_beat_t beat_r, beat_nxt;

  function automatic logic [5:0] mod7(input logic [6:0] v, input logic [5:0] d);
    logic [6:0] r2;
    logic [5:0] r;
    r = '0;
    for (int i = 6; i >= 0; i--) begin
      r2 = {r, v[i]};
      if (r2 >= {1'b0, d}) begin
        r2 = r2 - {1'b0, d};
      end
      r = r2[5:0];
    end
    return r;
  endfunction

  always_comb begin
    logic [22:0] pe;
    logic [22:0] po;
    logic [23:0] num;
    pe    = {6'd0, beat_in.xe} * {17'd0, 6'(beat_in.nl - 6'd1)};
    po    = {6'd0, beat_in.xo} * {17'd0, beat_in.nl};
    num   = {1'b0, pe} + cprgd_pkg::RoundBias - {1'b0, po};
    t_nxt = num[23:17];
  end

  // (t - 60) mod ni, taken as (t mod ni) - (60 mod ni) with wrap
  always_comb begin
    logic [5:0] rt;
    logic [5:0] r60;
    logic [5:0] mm;
    rt  = mod7(t_r, nl_r);
    r60 = mod7(7'd60, nl_r);
    if (rt >= r60) begin
      mm = rt - r60;
    end else begin
      mm = 6'(rt + nl_r - r60);
    end
    beat_nxt.valid = valid_r;
    beat_nxt.rem   = mm;
    beat_nxt.word  = {xe_r, 15'd0};
    beat_nxt.lat   = lat_r;
    beat_nxt.nl    = nl_r;
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    xe_r    <= beat_in.xe;
    nl_r    <= beat_in.nl;
    lat_r   <= beat_in.lat;
    if (!rst_n) begin
      valid_r      <= 1'b0;
      beat_r.valid <= 1'b0;
    end else begin
      valid_r <= beat_in.valid;
      beat_r  <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule
`default_nettype wire

/* hw/rtl/cprgd_div_stage.sv */
`default_nettype none
module cprgd_div_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  cprgd_pkg::div_beat_t     beat_in,
  output cprgd_pkg::div_beat_t     beat_out
);

  cprgd_pkg::div_beat_t beat_r, beat_nxt;

  // restoring division: take dividend bits off the top, shift quotient bits in at the bottom
  always_comb begin
    logic [6:0]  r2;
    logic [5:0]  r;
    logic [31:0] w;
    r = beat_in.rem;
    w = beat_in.word;
    for (int i = 0; i < cprgd_pkg::DivSteps; i++) begin
      r2 = {r, w[31]};
      if (r2 >= {1'b0, beat_in.nl}) begin
        r2 = r2 - {1'b0, beat_in.nl};
        w  = {w[30:0], 1'b1};
      end else begin
        w  = {w[30:0], 1'b0};
      end
      r = r2[5:0];
    end
    beat_nxt       = beat_in;
    beat_nxt.rem   = r;
    beat_nxt.word  = w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule
`default_nettype wire

/* hw/rtl/cpr_global_position_decode.sv */
// Each start is registered through the latitude, zone, longitude and divide stages.
// Throughput: one beat per cycle; busy stays low, so start may be high in every cycle.
// The longitude divide takes four stages of eight quotient bits each and sets the depth.
// Reset: synchronous, active low; clears all stage valid bits, so no strobe follows reset.
// The receiver cannot stall: each result is on the out_ ports for one cycle only.
`default_nettype none
module cpr_global_position_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [16:0]        in_lat_even_cpr,
  input  wire logic [16:0]        in_lat_odd_cpr,
  input  wire logic [16:0]        in_lon_even_cpr,
  input  wire logic [16:0]        in_lon_odd_cpr,
  output logic                    out_valid,
  output logic signed [23:0]      out_latitude_units,
  output logic signed [31:0]      out_longitude_angle,
  output logic [5:0]              out_zone_count
);

  cprgd_pkg::lat_beat_t  lat_beat;
  cprgd_pkg::zone_beat_t zone_beat;
  cprgd_pkg::div_beat_t  div_beat [cprgd_pkg::DivStages+1];

  assign busy = 1'b0;

  cprgd_lat u_lat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .le       (in_lat_even_cpr),
    .lo       (in_lat_odd_cpr),
    .xe       (in_lon_even_cpr),
    .xo       (in_lon_odd_cpr),
    .beat_out (lat_beat)
  );

  cprgd_zone u_zone (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_in  (lat_beat),
    .beat_out (zone_beat)
  );

  cprgd_lon u_lon (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_in  (zone_beat),
    .beat_out (div_beat[0])
  );

  for (genvar g = 0; g < cprgd_pkg::DivStages; g++) begin : g_div
    cprgd_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .beat_in  (div_beat[g]),
      .beat_out (div_beat[g+1])
    );
  end

  assign out_valid           = div_beat[cprgd_pkg::DivStages].valid;
  assign out_latitude_units  = div_beat[cprgd_pkg::DivStages].lat;
  assign out_longitude_angle = $signed(div_beat[cprgd_pkg::DivStages].word);
  assign out_zone_count      = div_beat[cprgd_pkg::DivStages].nl;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##9 out_valid) else $error("result strobe missing");

  a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zone_count != 6'd0) && (out_zone_count <= 6'd59))
    else $error("zone count out of range");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_latitude_units >= -24'sd1966080) &&
                  (out_latitude_units <= 24'sd5898239))
    else $error("latitude out of range");

  a_divide_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> div_beat[cprgd_pkg::DivStages].rem < out_zone_count)
    else $error("divide remainder not below divisor");

endmodule
`default_nettype wire

/* tb/cpr_global_position_decode_tb.sv */
`timescale 1ns / 100ps
module cpr_global_position_decode_tb;

  typedef struct {
    logic signed [cprgd_pkg::LatBits-1:0]   lat;
    logic signed [cprgd_pkg::AngleBits-1:0] lon;
    logic [cprgd_pkg::NlBits-1:0]           nl;
  } position_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [16:0] in_lat_even_cpr = '0;
  logic [16:0] in_lat_odd_cpr = '0;
  logic [16:0] in_lon_even_cpr = '0;
  logic [16:0] in_lon_odd_cpr = '0;
  logic out_valid;
  logic signed [23:0] out_latitude_units;
  logic signed [31:0] out_longitude_angle;
  logic [5:0] out_zone_count;

  position_t expected_positions[$];
  int error_count = 0;
  int idle_pct = 0;

  cpr_global_position_decode dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_lat_even_cpr(in_lat_even_cpr), .in_lat_odd_cpr(in_lat_odd_cpr),
    .in_lon_even_cpr(in_lon_even_cpr), .in_lon_odd_cpr(in_lon_odd_cpr),
    .out_valid(out_valid), .out_latitude_units(out_latitude_units),
    .out_longitude_angle(out_longitude_angle), .out_zone_count(out_zone_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("** cpr_global_position_decode: FAILED **");
    $finish;
  end

  function automatic position_t decode_position(logic [16:0] le, logic [16:0] lo,
                                                logic [16:0] xe, logic [16:0] xo);
    position_t p;
    longint num, j, lat, nl, m, mm, angle;
    num = 59 * longint'(le) - 60 * longint'(lo) + 65536 + 60 * 131072;
    j = num / 131072;
    lat = (j % 60) * 131072 + longint'(le);
    if (lat >= 5898240) lat -= 7864320;
    nl = cprgd_pkg::NlMax;
    for (int i = 0; i < cprgd_pkg::NlLimits; i++)
      if ((lat < 0 ? -lat : lat) >= longint'(cprgd_pkg::NL_LIMIT[i])) nl--;
    // m uses the same 60-zone offset to keep the dividend positive
    num = longint'(xe) * (nl - 1) - longint'(xo) * nl + 65536 + 60 * 131072;
    m = num / 131072 - 60;
    mm = ((m % nl) + nl) % nl;
    angle = ((mm * 131072 + longint'(xe)) << 15) / nl;
    p.lat = lat[23:0];
    p.lon = angle[31:0];
    p.nl = nl[5:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    position_t want;
    if (rst_n && out_valid) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_positions.pop_front();
        if (out_latitude_units !== want.lat)
          report_mismatch("latitude", out_latitude_units, want.lat);
        if (out_longitude_angle !== want.lon)
          report_mismatch("longitude", out_longitude_angle, want.lon);
        if (out_zone_count !== want.nl)
          report_mismatch("zone count", out_zone_count, want.nl);
      end
    end
  end

  task automatic send_beat(logic [16:0] le, logic [16:0] lo, logic [16:0] xe, logic [16:0] xo);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_lat_even_cpr <= le;
    in_lat_odd_cpr <= lo;
    in_lon_even_cpr <= xe;
    in_lon_odd_cpr <= xo;
    do @(posedge clk); while (busy);
    expected_positions.push_back(decode_position(le, lo, xe, xo));
  endtask

  // odd latitude that lands the even frame in latitude zone j
  function automatic logic [16:0] odd_for_zone(logic [16:0] le, int j);
    longint lo;
    lo = (59 * longint'(le) + 65536 - longint'(j) * 131072
          - longint'($urandom_range(131071))) / 60;
    if (lo < 0) lo = 0;
    if (lo > 131071) lo = 131071;
    return lo[16:0];
  endfunction

  task automatic drain;
    start <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed;
    idle_pct = 0;
    send_beat(17'd0, 17'd0, 17'd0, 17'd0);
    send_beat(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_beat(17'h1FFFF, 17'd0, 17'h1FFFF, 17'd0);
    send_beat(17'd0, 17'h1FFFF, 17'd0, 17'h1FFFF);
    send_beat(17'h15555, 17'h0AAAA, 17'h15555, 17'h0AAAA);
    send_beat(17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555);
    // polar zone (single longitude zone) north and south
    send_beat(17'd100000, 17'd67759, 17'd5000, 17'd90000);
    send_beat(17'd20000, 17'd52000, 17'd1, 17'd131071);
    for (int j = 0; j < 60; j += 5)
      send_beat(17'($urandom_range(131071)), odd_for_zone(17'd70000, j),
                17'($urandom_range(131071)), 17'($urandom_range(131071)));
    send_beat(17'd70000, odd_for_zone(17'd70000, 14), 17'h1FFFF, 17'd0);
    send_beat(17'd70000, odd_for_zone(17'd70000, -15), 17'd0, 17'h1FFFF);
    drain();
  endtask

  task automatic test_random(int count, int pct);
    logic [16:0] le;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      le = 17'($urandom_range(131071));
      if ($urandom_range(3) == 0)
        send_beat(le, 17'($urandom_range(131071)), 17'($urandom_range(131071)),
                  17'($urandom_range(131071)));
      else
        send_beat(le, odd_for_zone(le, int'($urandom_range(118)) - 59),
                  17'($urandom_range(131071)), 17'($urandom_range(131071)));
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 0);
    test_random(500, 59);
    test_random(500, 13);
    test_random(500, 0);
    start <= 1'b0;
    for (int k = 0; k < 1000 && expected_positions.size() != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_positions.size() == 0)
      $display("** cpr_global_position_decode: PASSED **");
    else
      $display("** cpr_global_position_decode: FAILED **");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/cprgd_pkg.sv
hw/rtl/cprgd_lat.sv
hw/rtl/cprgd_zone.sv
hw/rtl/cprgd_lon.sv
hw/rtl/cprgd_div_stage.sv
hw/rtl/cpr_global_position_decode.sv
tb/cpr_global_position_decode_tb.sv
